// ----- hw/rtl/pfb_pkg.sv -----
// Shared types, constants and the 5x7 glyph table of the page framebuffer text plotter.
`timescale 1ns / 1ps

package pfb_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_CHAR  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    COLOR_BLACK  = 2'd0,
    COLOR_WHITE  = 2'd1,
    COLOR_INVERT = 2'd2,
    COLOR_KEEP   = 2'd3
  } color_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic sweep_step;
    logic load_glyph;
    logic mem_read;
    logic mem_write;
    logic step_next;
    logic set_status;
    logic out_load;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_clear;
    logic sweep_last;
    logic step_active;
    logic step_last;
    logic out_free;
  } sts_t;

  localparam logic [7:0] FIRST_CODE    = 8'd32;
  localparam logic [7:0] LAST_CODE     = 8'd126;
  localparam logic [2:0] BLANK_COL     = 3'd5;
  localparam logic [3:0] LAST_STEP     = 4'd11;
  localparam int         GLYPH_ENTRIES = 475;

  // Five column bytes per printable code, bit 0 at the top row.
  localparam logic [7:0] GLYPH_ROM [GLYPH_ENTRIES] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5F, 8'h00, 8'h00,
    8'h00, 8'h07, 8'h00, 8'h07, 8'h00, 8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14,
    8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12, 8'h23, 8'h13, 8'h08, 8'h64, 8'h62,
    8'h36, 8'h49, 8'h56, 8'h20, 8'h50, 8'h00, 8'h08, 8'h07, 8'h03, 8'h00,
    8'h00, 8'h1C, 8'h22, 8'h41, 8'h00, 8'h00, 8'h41, 8'h22, 8'h1C, 8'h00,
    8'h2A, 8'h1C, 8'h7F, 8'h1C, 8'h2A, 8'h08, 8'h08, 8'h3E, 8'h08, 8'h08,
    8'h00, 8'h80, 8'h70, 8'h30, 8'h00, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08,
    8'h00, 8'h00, 8'h60, 8'h60, 8'h00, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02,
    8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E, 8'h00, 8'h42, 8'h7F, 8'h40, 8'h00,
    8'h72, 8'h49, 8'h49, 8'h49, 8'h46, 8'h21, 8'h41, 8'h49, 8'h4D, 8'h33,
    8'h18, 8'h14, 8'h12, 8'h7F, 8'h10, 8'h27, 8'h45, 8'h45, 8'h45, 8'h39,
    8'h3C, 8'h4A, 8'h49, 8'h49, 8'h31, 8'h41, 8'h21, 8'h11, 8'h09, 8'h07,
    8'h36, 8'h49, 8'h49, 8'h49, 8'h36, 8'h46, 8'h49, 8'h49, 8'h29, 8'h1E,
    8'h00, 8'h00, 8'h14, 8'h00, 8'h00, 8'h00, 8'h40, 8'h34, 8'h00, 8'h00,
    8'h00, 8'h08, 8'h14, 8'h22, 8'h41, 8'h14, 8'h14, 8'h14, 8'h14, 8'h14,
    8'h00, 8'h41, 8'h22, 8'h14, 8'h08, 8'h02, 8'h01, 8'h59, 8'h09, 8'h06,
    8'h3E, 8'h41, 8'h5D, 8'h59, 8'h4E, 8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C,
    8'h7F, 8'h49, 8'h49, 8'h49, 8'h36, 8'h3E, 8'h41, 8'h41, 8'h41, 8'h22,
    8'h7F, 8'h41, 8'h41, 8'h41, 8'h3E, 8'h7F, 8'h49, 8'h49, 8'h49, 8'h41,
    8'h7F, 8'h09, 8'h09, 8'h09, 8'h01, 8'h3E, 8'h41, 8'h41, 8'h51, 8'h73,
    8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F, 8'h00, 8'h41, 8'h7F, 8'h41, 8'h00,
    8'h20, 8'h40, 8'h41, 8'h3F, 8'h01, 8'h7F, 8'h08, 8'h14, 8'h22, 8'h41,
    8'h7F, 8'h40, 8'h40, 8'h40, 8'h40, 8'h7F, 8'h02, 8'h1C, 8'h02, 8'h7F,
    8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F, 8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E,
    8'h7F, 8'h09, 8'h09, 8'h09, 8'h06, 8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E,
    8'h7F, 8'h09, 8'h19, 8'h29, 8'h46,
    8'h26, 8'h49, 8'h49, 8'h49, 8'h32, 8'h03, 8'h01, 8'h7F, 8'h01, 8'h03,
    8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F, 8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F,
    8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F, 8'h63, 8'h14, 8'h08, 8'h14, 8'h63,
    8'h03, 8'h04, 8'h78, 8'h04, 8'h03, 8'h61, 8'h59, 8'h49, 8'h4D, 8'h43,
    8'h00, 8'h7F, 8'h41, 8'h41, 8'h41, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
    8'h00, 8'h41, 8'h41, 8'h41, 8'h7F, 8'h04, 8'h02, 8'h01, 8'h02, 8'h04,
    8'h40, 8'h40, 8'h40, 8'h40, 8'h40, 8'h00, 8'h03, 8'h07, 8'h08, 8'h00,
    8'h20, 8'h54, 8'h54, 8'h78, 8'h40, 8'h7F, 8'h28, 8'h44, 8'h44, 8'h38,
    8'h38, 8'h44, 8'h44, 8'h44, 8'h28, 8'h38, 8'h44, 8'h44, 8'h28, 8'h7F,
    8'h38, 8'h54, 8'h54, 8'h54, 8'h18, 8'h00, 8'h08, 8'h7E, 8'h09, 8'h02,
    8'h18, 8'hA4, 8'hA4, 8'h9C, 8'h78, 8'h7F, 8'h08, 8'h04, 8'h04, 8'h78,
    8'h00, 8'h44, 8'h7D, 8'h40, 8'h00, 8'h20, 8'h40, 8'h40, 8'h3D, 8'h00,
    8'h7F, 8'h10, 8'h28, 8'h44, 8'h00, 8'h00, 8'h41, 8'h7F, 8'h40, 8'h00,
    8'h7C, 8'h04, 8'h78, 8'h04, 8'h78, 8'h7C, 8'h08, 8'h04, 8'h04, 8'h78,
    8'h38, 8'h44, 8'h44, 8'h44, 8'h38, 8'hFC, 8'h18, 8'h24, 8'h24, 8'h18,
    8'h18, 8'h24, 8'h24, 8'h18, 8'hFC, 8'h7C, 8'h08, 8'h04, 8'h04, 8'h08,
    8'h48, 8'h54, 8'h54, 8'h54, 8'h24, 8'h04, 8'h04, 8'h3F, 8'h44, 8'h24,
    8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C, 8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C,
    8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C, 8'h44, 8'h28, 8'h10, 8'h28, 8'h44,
    8'h4C, 8'h90, 8'h90, 8'h90, 8'h7C, 8'h44, 8'h64, 8'h54, 8'h4C, 8'h44,
    8'h00, 8'h08, 8'h36, 8'h41, 8'h00, 8'h00, 8'h00, 8'h77, 8'h00, 8'h00,
    8'h00, 8'h41, 8'h36, 8'h08, 8'h00, 8'h02, 8'h01, 8'h02, 8'h04, 8'h02
  };

endpackage

// ----- hw/rtl/pfb_cmd_if.sv -----
// Command channel interface: valid, ready and one command word.
`timescale 1ns / 1ps

interface pfb_cmd_if import pfb_pkg::*; ();
  logic       valid;
  logic       ready;
  cmd_t       cmd;
  logic [7:0] x_coord;
  logic [7:0] y_coord;
  color_t     pixel_color;
  logic [7:0] glyph_code;

  modport source (
    output valid, cmd, x_coord, y_coord, pixel_color, glyph_code,
    input  ready
  );
  modport sink (
    input  valid, cmd, x_coord, y_coord, pixel_color, glyph_code,
    output ready
  );
endinterface

// ----- hw/rtl/pfb_rsp_if.sv -----
// Result channel interface: valid, ready and one result word.
`timescale 1ns / 1ps

interface pfb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       status;

  modport source (
    output valid, read_byte, status,
    input  ready
  );
  modport sink (
    input  valid, read_byte, status,
    output ready
  );
endinterface

// ----- hw/rtl/pfb_ctrl.sv -----
// Controller state machine that sequences sweeps, glyph fetches and read-modify-writes.
`timescale 1ns / 1ps

module pfb_ctrl import pfb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_CLR   = 7'b0000100,
    S_LOAD  = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_INIT: begin
        ctl.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = sts.in_is_clear ? S_CLR : S_LOAD;
        end
      end
      S_CLR: begin
        ctl.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_DONE;
        end
      end
      S_LOAD: begin
        ctl.load_glyph = 1'b1;
        state_nxt      = S_CHECK;
      end
      S_CHECK: begin
        ctl.set_status = 1'b1;
        if (sts.step_active) begin
          ctl.mem_read = 1'b1;
          state_nxt    = S_WRITE;
        end else if (sts.step_last) begin
          state_nxt = S_DONE;
        end else begin
          ctl.step_next = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      S_WRITE: begin
        ctl.mem_write = 1'b1;
        if (sts.step_last) begin
          state_nxt = S_DONE;
        end else begin
          ctl.step_next = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule

// ----- hw/rtl/pfb_datapath.sv -----
// Datapath: command registers, step addressing and masks, glyph fetch, frame store, result register.
`timescale 1ns / 1ps

module pfb_datapath import pfb_pkg::*; #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ctl_t       ctl,
  output sts_t       sts,
  input  cmd_t       in_cmd,
  input  logic [7:0] in_x_coord,
  input  logic [7:0] in_y_coord,
  input  color_t     in_pixel_color,
  input  logic [7:0] in_glyph_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_byte,
  output logic       out_status
);

  localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int FULL_PAGES  = SCREEN_HEIGHT / 8;
  localparam int H_REM       = SCREEN_HEIGHT % 8;

  localparam logic [5:0]        FULL_PAGES_W = 6'(FULL_PAGES);
  localparam logic [7:0]        REM_MASK     = 8'((1 << H_REM) - 1);
  localparam logic [8:0]        WIDTH_W      = 9'(SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(STORE_BYTES - 1);

  logic [7:0] frame_mem [STORE_BYTES];

  cmd_t              cmd_r;
  color_t            color_r;
  logic [7:0]        x_r;
  logic [7:0]        y_r;
  logic [7:0]        code_r;
  logic [3:0]        sidx_r;
  logic [6:0]        glyph_r;
  logic [ADDR_W-1:0] sweep_r;
  logic [7:0]        rdata_r;
  logic [7:0]        rd_r;
  logic              status_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_status_r;

  logic              is_char;
  logic              unprintable;
  logic [2:0]        col;
  logic              half;
  logic [8:0]        px;
  logic [5:0]        page;
  logic [15:0]       data_wide;
  logic [15:0]       mask_wide;
  logic [7:0]        char_mask;
  logic [7:0]        char_data;
  logic [7:0]        step_mask;
  logic [7:0]        page_rows;
  logic              col_ok;
  logic [7:0]        eff_mask;
  logic              step_active;
  logic [15:0]       addr_full;
  logic [ADDR_W-1:0] mem_addr;
  logic [8:0]        code_off;
  logic [8:0]        glyph_idx;
  logic [7:0]        new_byte;
  logic              mem_we;
  logic [7:0]        mem_wdata;

  assign is_char     = (cmd_r == CMD_CHAR);
  assign unprintable = (code_r < FIRST_CODE) || (code_r > LAST_CODE);
  assign col         = is_char ? sidx_r[3:1] : 3'd0;
  assign half        = is_char & sidx_r[0];
  assign px          = {1'b0, x_r} + {6'd0, col};
  assign page        = {1'b0, y_r[7:3]} + {5'd0, half};

  // The seven glyph rows straddle at most two pages; the upper byte of the
  // shifted column covers the second page.
  assign data_wide = {9'd0, glyph_r} << y_r[2:0];
  assign mask_wide = 16'h007F << y_r[2:0];
  assign char_mask = half ? mask_wide[15:8] : mask_wide[7:0];
  assign char_data = half ? data_wide[15:8] : data_wide[7:0];
  assign step_mask = is_char ? char_mask : (8'h01 << y_r[2:0]);

  // Rows of this page that lie inside the screen height.
  always_comb begin
    if (page < FULL_PAGES_W) begin
      page_rows = 8'hFF;
    end else if (page == FULL_PAGES_W) begin
      page_rows = REM_MASK;
    end else begin
      page_rows = 8'h00;
    end
  end

  assign col_ok      = (px < WIDTH_W);
  assign eff_mask    = step_mask & page_rows & {8{col_ok}};
  assign step_active = (eff_mask != 8'h00) && !(is_char && unprintable);

  assign addr_full = 16'(page) * 16'(SCREEN_WIDTH) + {7'd0, px};
  assign mem_addr  = ctl.sweep_step ? sweep_r : addr_full[ADDR_W-1:0];

  assign code_off  = {1'b0, code_r - FIRST_CODE};
  assign glyph_idx = (code_off << 2) + code_off + {6'd0, col};

  always_comb begin
    if (is_char) begin
      new_byte = (rdata_r & ~eff_mask) | (char_data & eff_mask);
    end else begin
      case (color_r)
        COLOR_BLACK:  new_byte = rdata_r & ~eff_mask;
        COLOR_WHITE:  new_byte = rdata_r | eff_mask;
        COLOR_INVERT: new_byte = rdata_r ^ eff_mask;
        default:      new_byte = rdata_r;
      endcase
    end
  end

  assign mem_we = ctl.sweep_step ||
                  (ctl.mem_write &&
                   (is_char || ((cmd_r == CMD_PIXEL) && (color_r != COLOR_KEEP))));
  assign mem_wdata = ctl.sweep_step ? 8'h00 : new_byte;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_addr] <= mem_wdata;
    end
    if (ctl.mem_read) begin
      rdata_r <= frame_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      sidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.capture) begin
        sweep_r <= '0;
      end else if (ctl.sweep_step) begin
        sweep_r <= sweep_r + 1'b1;
      end
      if (ctl.capture) begin
        sidx_r <= '0;
      end else if (ctl.step_next) begin
        sidx_r <= sidx_r + 4'd1;
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r    <= in_cmd;
      color_r  <= in_pixel_color;
      x_r      <= in_x_coord;
      y_r      <= in_y_coord;
      code_r   <= in_glyph_code;
      rd_r     <= 8'h00;
      status_r <= 1'b0;
    end else begin
      if (ctl.set_status) begin
        status_r <= is_char ? unprintable : !step_active;
      end
      if (ctl.mem_write && (cmd_r == CMD_READ)) begin
        rd_r <= rdata_r;
      end
    end
    if (ctl.load_glyph) begin
      glyph_r <= (col == BLANK_COL || unprintable) ? 7'h00 : GLYPH_ROM[glyph_idx][6:0];
    end
    if (ctl.out_load) begin
      out_byte_r   <= rd_r;
      out_status_r <= status_r;
    end
  end

  assign sts.in_is_clear = (in_cmd == CMD_CLEAR);
  assign sts.sweep_last  = (sweep_r == LAST_ADDR);
  assign sts.step_active = step_active;
  assign sts.step_last   = !is_char || unprintable || (sidx_r == LAST_STEP);
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_read_byte = out_byte_r;
  assign out_status    = out_status_r;

endmodule

// ----- hw/rtl/page_framebuffer_text_plotter.sv -----
// Top level of the monochrome page framebuffer with a 5x7 text plotter.
`timescale 1ns / 1ps

// The block keeps a one-bit-per-pixel frame store in which pixel (x,y) is bit y%8 of
// byte x + (y/8)*SCREEN_WIDTH. Each command word on in_ch clears the store, plots one
// pixel, draws one printable character (codes 32..126, five glyph columns plus a blank
// sixth) or reads one byte. Every command word yields exactly one result word on
// out_ch: the byte read (zero for other commands) and a status bit that is set when
// a pixel or read was ignored as off screen or a character code was unprintable.
// One command is worked on at a time, and the single frame store port sets the pace:
// a byte update is a read followed by a write. A read or an on-screen pixel passes
// through the load, check (store read), write and done states; an off-screen pixel,
// read or unprintable code skips the write state. A character takes twelve
// column/page steps, each a load and a check, with a write for every byte touched,
// then the result is loaded. A clear zeroes SCREEN_WIDTH*ceil(SCREEN_HEIGHT/8) bytes
// (1024 at the default size), one byte per cycle. in_ch is ready again in the cycle
// after the result is loaded. After reset the store is swept to zero the same way,
// and in_ch stays not ready until the sweep ends.
// The result sits in an output register, so a new command is taken while an earlier
// result waits; if the receiver still stalls when the next result is ready, the
// block holds that result internally and takes no further command until it moves.

module page_framebuffer_text_plotter import pfb_pkg::*; #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input logic              clk,
  input logic              rst_n,
  pfb_cmd_if.sink          in_ch,
  pfb_rsp_if.source        out_ch
);

  ctl_t ctl;
  sts_t sts;
  logic in_ready;

  // Sequencing: sweep, glyph fetch, read and write of each step, result hand-off.
  pfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Frame store, addressing and masking of each step, and the result register.
  pfb_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .in_cmd         (in_ch.cmd),
    .in_x_coord     (in_ch.x_coord),
    .in_y_coord     (in_ch.y_coord),
    .in_pixel_color (in_ch.pixel_color),
    .in_glyph_code  (in_ch.glyph_code),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_read_byte  (out_ch.read_byte),
    .out_status     (out_ch.status)
  );

  assign in_ch.ready = in_ready;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the page framebuffer text plotter: directed table, then random words.
`timescale 1ns / 1ps

// The testbench keeps its own copy of the frame store and draws into it exactly as
// the block should, so every result word is known before the block produces it.
// A short table of directed words comes first: reads after reset, the screen
// corners, off-screen pixels, every pixel color, unprintable codes, characters
// that run off the right and bottom edges, and a clear. The rows whose answer is
// obvious carry their expected result. The remaining rows, and about 1800 random
// words after them, are checked against the shadow store. The random part runs in
// four stretches: no idling, an idle sender, a stalling receiver, and both at once.

module testbench;
  import pfb_pkg::*;

  localparam int SCREEN_W = 128;
  localparam int SCREEN_H = 64;
  localparam int FB_BYTES = SCREEN_W * ((SCREEN_H + 7) / 8);
  localparam int GLYPH_W  = 5;
  localparam int GLYPH_H  = 7;
  localparam int SCRIPT_ROWS = 26;
  localparam int RANDOM_WORDS = 1800;
  localparam int MAX_REPORTS = 10;

  // One command word as the sender presents it.
  typedef struct packed {
    cmd_t       op;
    logic [7:0] x;
    logic [7:0] y;
    color_t     color;
    logic [7:0] code;
  } draw_word_t;

  // One result word: the byte read and the ignored flag.
  typedef struct packed {
    logic [7:0] rd_byte;
    logic       ignored;
  } reply_t;

  // A row of the directed table. When fixed is set, want is the expected reply.
  typedef struct packed {
    draw_word_t word;
    logic       fixed;
    reply_t     want;
  } script_row_t;

  logic clk;
  logic rst_n;

  pfb_cmd_if cmd_bus ();
  pfb_rsp_if rsp_bus ();

  page_framebuffer_text_plotter #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (cmd_bus),
    .out_ch(rsp_bus)
  );

  // Shadow copy of the frame store, updated when a word is accepted.
  logic [7:0] shadow_fb [FB_BYTES];

  reply_t      replies_due[$];
  script_row_t script [SCRIPT_ROWS];

  int unsigned idle_pct;
  int unsigned stall_pct;
  int          mismatches;
  int          replies_seen;
  int          words_sent;
  int          op_tally [4];
  int          last_x;
  int          last_y;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard limit, far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Sets, clears, toggles or keeps one shadow pixel. Returns 0 when it is off screen.
  function automatic bit shadow_plot(input int px, input int py, input color_t color);
    int         addr;
    logic [7:0] mask;
    if (px >= SCREEN_W || py >= SCREEN_H) return 1'b0;
    addr = px + (py / 8) * SCREEN_W;
    mask = 8'h01 << (py % 8);
    case (color)
      COLOR_BLACK:  shadow_fb[addr] = shadow_fb[addr] & ~mask;
      COLOR_WHITE:  shadow_fb[addr] = shadow_fb[addr] | mask;
      COLOR_INVERT: shadow_fb[addr] = shadow_fb[addr] ^ mask;
      default: ;
    endcase
    return 1'b1;
  endfunction

  // Applies one accepted word to the shadow store and returns the reply it must
  // produce. Glyph bits are drawn as white or black, the color field plays no part,
  // and row 7 of a glyph column is never drawn.
  function automatic reply_t shadow_apply(input draw_word_t w);
    reply_t     r;
    int         base;
    logic [7:0] column;
    r = '0;
    case (w.op)
      CMD_CLEAR: begin
        foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
      end
      CMD_PIXEL: begin
        r.ignored = !shadow_plot(int'(w.x), int'(w.y), w.color);
      end
      CMD_CHAR: begin
        if (w.code < FIRST_CODE || w.code > LAST_CODE) begin
          r.ignored = 1'b1;
        end else begin
          base = (int'(w.code) - int'(FIRST_CODE)) * GLYPH_W;
          for (int col = 0; col < GLYPH_W; col++) begin
            column = GLYPH_ROM[base + col];
            for (int row = 0; row < GLYPH_H; row++) begin
              void'(shadow_plot(int'(w.x) + col, int'(w.y) + row,
                                column[row] ? COLOR_WHITE : COLOR_BLACK));
            end
          end
          // The spacing column after the glyph is always black.
          for (int row = 0; row < GLYPH_H; row++) begin
            void'(shadow_plot(int'(w.x) + GLYPH_W, int'(w.y) + row, COLOR_BLACK));
          end
        end
      end
      default: begin
        if (w.x < SCREEN_W && w.y < SCREEN_H) begin
          r.rd_byte = shadow_fb[int'(w.x) + (int'(w.y) / 8) * SCREEN_W];
        end else begin
          r.ignored = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // Presents one word, with random idle cycles ahead of it, and holds it until the
  // block takes it. Valid is written once per cycle, so back-to-back words keep it
  // high without a glitch.
  task automatic offer_word(input draw_word_t w, input bit fixed, input reply_t want);
    reply_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.cmd         <= w.op;
    cmd_bus.x_coord     <= w.x;
    cmd_bus.y_coord     <= w.y;
    cmd_bus.pixel_color <= w.color;
    cmd_bus.glyph_code  <= w.code;
    @(posedge clk);
    while (cmd_bus.ready !== 1'b1) @(posedge clk);
    // The word was taken at this edge. The shadow store is always updated, even
    // when the table already states the answer.
    predicted = shadow_apply(w);
    replies_due.push_back(fixed ? want : predicted);
    op_tally[w.op]++;
    words_sent++;
  endtask

  // Random words: mostly on or just past the screen edges, printable codes, and
  // reads aimed near the last thing drawn so that they see real content. A few
  // words use the full field range so every bit of every field toggles.
  function automatic draw_word_t random_word();
    draw_word_t  w;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 2) w.op = CMD_CLEAR;
    else if (pick < 37) w.op = CMD_PIXEL;
    else if (pick < 62) w.op = CMD_CHAR;
    else w.op = CMD_READ;
    if ($urandom_range(9) == 0) begin
      w.x = 8'($urandom_range(255));
      w.y = 8'($urandom_range(255));
    end else if (w.op == CMD_READ && $urandom_range(1) == 1) begin
      w.x = 8'(last_x + int'($urandom_range(6)));
      w.y = 8'(last_y + int'($urandom_range(7)));
    end else begin
      w.x = 8'($urandom_range(SCREEN_W + 5));
      w.y = 8'($urandom_range(SCREEN_H + 7));
    end
    w.color = color_t'($urandom_range(3));
    if ($urandom_range(9) == 0) w.code = 8'($urandom_range(255));
    else w.code = 8'($urandom_range(LAST_CODE, FIRST_CODE));
    return w;
  endfunction

  // Receiver: stalls at random and checks each accepted result word against the
  // oldest expected reply.
  always @(posedge clk) begin
    reply_t want;
    if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result word: read_byte=%02h status=%0b",
                   rsp_bus.read_byte, rsp_bus.status);
        end
      end else begin
        want = replies_due.pop_front();
        if (rsp_bus.read_byte !== want.rd_byte || rsp_bus.status !== want.ignored) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result %0d: expected read_byte=%02h status=%0b, got %02h %0b",
                     replies_seen, want.rd_byte, want.ignored,
                     rsp_bus.read_byte, rsp_bus.status);
          end
        end
      end
    end
    rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    draw_word_t w;
    rst_n               = 1'b0;
    cmd_bus.valid       = 1'b0;
    cmd_bus.cmd         = CMD_CLEAR;
    cmd_bus.x_coord     = 8'd0;
    cmd_bus.y_coord     = 8'd0;
    cmd_bus.pixel_color = COLOR_BLACK;
    cmd_bus.glyph_code  = 8'd0;
    rsp_bus.ready       = 1'b0;
    idle_pct            = 0;
    stall_pct           = 0;
    mismatches          = 0;
    replies_seen        = 0;
    words_sent          = 0;
    last_x              = 0;
    last_y              = 0;
    foreach (op_tally[i]) op_tally[i] = 0;
    foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;

    // Directed table: word, fixed answer given, expected reply.
    script = '{
      // The store reads back as zero after reset; off-screen reads are ignored.
      '{'{CMD_READ,  8'd0,   8'd0,   COLOR_KEEP,   8'd0},   1'b1, '{8'h00, 1'b0}},
      '{'{CMD_READ,  8'd255, 8'd255, COLOR_KEEP,   8'd0},   1'b1, '{8'h00, 1'b1}},
      '{'{CMD_READ,  8'd128, 8'd0,   COLOR_KEEP,   8'd0},   1'b1, '{8'h00, 1'b1}},
      '{'{CMD_READ,  8'd0,   8'd64,  COLOR_KEEP,   8'd0},   1'b1, '{8'h00, 1'b1}},
      // Opposite corners of the screen.
      '{'{CMD_PIXEL, 8'd0,   8'd0,   COLOR_WHITE,  8'd0},   1'b1, '{8'h00, 1'b0}},
      '{'{CMD_READ,  8'd0,   8'd0,   COLOR_KEEP,   8'd0},   1'b1, '{8'h01, 1'b0}},
      '{'{CMD_PIXEL, 8'd127, 8'd63,  COLOR_WHITE,  8'd0},   1'b1, '{8'h00, 1'b0}},
      '{'{CMD_READ,  8'd127, 8'd63,  COLOR_KEEP,   8'd0},   1'b1, '{8'h80, 1'b0}},
      // Pixels just past the right and bottom edges are skipped.
      '{'{CMD_PIXEL, 8'd128, 8'd0,   COLOR_WHITE,  8'd0},   1'b1, '{8'h00, 1'b1}},
      '{'{CMD_PIXEL, 8'd0,   8'd64,  COLOR_WHITE,  8'd0},   1'b1, '{8'h00, 1'b1}},
      // Toggle, keep and black on pixels already known.
      '{'{CMD_PIXEL, 8'd0,   8'd0,   COLOR_INVERT, 8'd0},   1'b1, '{8'h00, 1'b0}},
      '{'{CMD_PIXEL, 8'd127, 8'd63,  COLOR_KEEP,   8'd0},   1'b1, '{8'h00, 1'b0}},
      '{'{CMD_READ,  8'd127, 8'd56,  COLOR_KEEP,   8'd0},   1'b1, '{8'h80, 1'b0}},
      '{'{CMD_PIXEL, 8'd3,   8'd7,   COLOR_INVERT, 8'd0},   1'b1, '{8'h00, 1'b0}},
      '{'{CMD_PIXEL, 8'd3,   8'd7,   COLOR_BLACK,  8'd0},   1'b1, '{8'h00, 1'b0}},
      // Codes just outside the printable range, and the field extremes.
      '{'{CMD_CHAR,  8'd0,   8'd0,   COLOR_WHITE,  8'd31},  1'b1, '{8'h00, 1'b1}},
      '{'{CMD_CHAR,  8'd0,   8'd0,   COLOR_WHITE,  8'd127}, 1'b1, '{8'h00, 1'b1}},
      '{'{CMD_CHAR,  8'd255, 8'd255, COLOR_INVERT, 8'd255}, 1'b1, '{8'h00, 1'b1}},
      // A digit in the top left corner, then its first column read back.
      '{'{CMD_CHAR,  8'd0,   8'd0,   COLOR_BLACK,  8'd48},  1'b1, '{8'h00, 1'b0}},
      '{'{CMD_READ,  8'd0,   8'd0,   COLOR_KEEP,   8'd0},   1'b0, '{8'h00, 1'b0}},
      // Last printable code running off the right and bottom edges.
      '{'{CMD_CHAR,  8'd123, 8'd58,  COLOR_KEEP,   8'd126}, 1'b1, '{8'h00, 1'b0}},
      '{'{CMD_READ,  8'd126, 8'd63,  COLOR_KEEP,   8'd0},   1'b0, '{8'h00, 1'b0}},
      // A space drawn wholly off screen still counts as done.
      '{'{CMD_CHAR,  8'd250, 8'd250, COLOR_WHITE,  8'd32},  1'b1, '{8'h00, 1'b0}},
      // A glyph whose column bytes carry bit 7, which must not be drawn.
      '{'{CMD_CHAR,  8'd5,   8'd57,  COLOR_WHITE,  8'd103}, 1'b1, '{8'h00, 1'b0}},
      '{'{CMD_READ,  8'd6,   8'd64,  COLOR_KEEP,   8'd0},   1'b1, '{8'h00, 1'b1}},
      '{'{CMD_CLEAR, 8'd0,   8'd0,   COLOR_KEEP,   8'd0},   1'b1, '{8'h00, 1'b0}}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The block sweeps its store after reset and holds off commands meanwhile;
    // the sender simply waits on ready.
    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      offer_word(script[i].word, script[i].fixed, script[i].want);
    end
    // Read the byte of column 6 that holds the drawn rows of the lower-case g.
    offer_word('{CMD_READ, 8'd6, 8'd56, COLOR_KEEP, 8'd0}, 1'b0, '0);

    // Random stretches: no idling, idle sender, stalling receiver, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      for (int n = 0; n < RANDOM_WORDS / 4; n++) begin
        w = random_word();
        if (w.op == CMD_PIXEL || w.op == CMD_CHAR) begin
          last_x = int'(w.x);
          last_y = int'(w.y);
        end
        offer_word(w, 1'b0, '0);
      end
    end
    cmd_bus.valid <= 1'b0;

    // Drain: every expected reply must arrive, then nothing more may follow.
    while (replies_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("words sent: %0d (clear %0d, pixel %0d, char %0d, read %0d)", words_sent,
             op_tally[CMD_CLEAR], op_tally[CMD_PIXEL], op_tally[CMD_CHAR],
             op_tally[CMD_READ]);
    $display("results checked: %0d, mismatches: %0d", replies_seen, mismatches);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/pfb_pkg.sv
hw/rtl/pfb_cmd_if.sv
hw/rtl/pfb_rsp_if.sv
hw/rtl/pfb_ctrl.sv
hw/rtl/pfb_datapath.sv
hw/rtl/page_framebuffer_text_plotter.sv
tb/testbench.sv
